>>> sv/summed_area_table_region_sum_top_defines.svh
// Assertion macros shared by the summed-area table RTL.
`ifndef SUMMED_AREA_TABLE_REGION_SUM_TOP_DEFINES_SVH
`define SUMMED_AREA_TABLE_REGION_SUM_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/sat_pkg.sv
// Package with the types and constants of the summed-area table block.
package sat_pkg;

  // Default sizes of the table and the element width.
  localparam int MAX_ROWS_DEF     = 64;
  localparam int MAX_COLS_DEF     = 64;
  localparam int ELEMENT_BITS_DEF = 16;

  // Fixed field widths.
  localparam int TABLE_W  = 32;
  localparam int SUM_W    = 28;
  localparam int CORNER_W = 6;
  localparam int DIM_W    = 7;
  localparam int ELEM_W   = 16;
  localparam int CFG_IDX_W = 1;

  // Item modes.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

  // Saturation bounds of the region sum.
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic                       mode;
    logic signed [ELEM_W-1:0]   element_value;
    logic [CORNER_W-1:0]        top_row;
    logic [CORNER_W-1:0]        left_col;
    logic [CORNER_W-1:0]        bottom_row;
    logic [CORNER_W-1:0]        right_col;
  } sat_in_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]    region_sum;
    logic                       coord_error;
  } sat_out_t;

endpackage

>>> sv/summed_area_table_region_sum_top.sv
// Summed-area table builder with rectangle-sum queries, top level.
//
//  Channel   Handshake                 Payload
//  --------  ------------------------  -----------------------------
//  item      start / busy              sat_in_t (load or query)
//  result    done (one-cycle strobe)   sat_out_t (one per query)
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// For every item the accepting edge issues the first table reads,
// and busy is high for the following cycle, in which a load writes its entry
// and a query issues its second pair of reads on the two table read ports.
// A query result strobes on done from the result register after the second query stage; loads give none.
// Reset clears the load position, row sum and control; the table itself is not
// cleared. The receiver cannot stall, so done never waits.
`include "summed_area_table_region_sum_top_defines.svh"

module summed_area_table_region_sum_top #(
  parameter int MAX_ROWS     = sat_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS     = sat_pkg::MAX_COLS_DEF,
  parameter int ELEMENT_BITS = sat_pkg::ELEMENT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  sat_pkg::sat_in_t                      item,
  output logic                                  done,
  output sat_pkg::sat_out_t                     result,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sat_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sat_pkg::DIM_W-1:0]             cfg_data
);
  import sat_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RDW   = $clog2(MAX_ROWS + 1);
  localparam int CDW   = $clog2(MAX_COLS + 1);

  // Table address of entry (row, col) in row-major order.
  function automatic logic [AW-1:0] addr_of(logic [RIW-1:0] r, logic [CIW-1:0] c);
    logic [AW-1:0] base;
    base = AW'(r) * AW'(MAX_COLS);
    return base + AW'(c);
  endfunction

  // Configuration registers and their clamped values.
  logic [DIM_W-1:0] rows_in_use;
  logic [DIM_W-1:0] cols_in_use;
  logic [RDW-1:0]   rows_eff;
  logic [CDW-1:0]   cols_eff;

  always_comb begin
    if (rows_in_use == '0) begin
      rows_eff = RDW'(1);
    end else if (32'(rows_in_use) > MAX_ROWS) begin
      rows_eff = RDW'(MAX_ROWS);
    end else begin
      rows_eff = RDW'(rows_in_use);
    end
    if (cols_in_use == '0) begin
      cols_eff = CDW'(1);
    end else if (32'(cols_in_use) > MAX_COLS) begin
      cols_eff = CDW'(MAX_COLS);
    end else begin
      cols_eff = CDW'(cols_in_use);
    end
  end

  // Load state.
  logic [RIW-1:0]     load_row;
  logic [CIW-1:0]     load_col;
  logic [TABLE_W-1:0] row_running_sum;

  // First stage (busy cycle) and second query stage.
  logic               s1_valid;
  logic               s1_mode;
  logic               s1_err;
  logic               s1_tnz;
  logic               s1_lnz;
  logic               s1_above;
  logic [AW-1:0]      s1_waddr;
  logic [RIW-1:0]     s1_brow;
  logic [RIW-1:0]     s1_tm1;
  logic [CIW-1:0]     s1_lm1;
  logic               s2_valid;
  logic               s2_err;
  logic               s2_tnz;
  logic               s2_lnz;
  logic [TABLE_W-1:0] s2_acc;

  // Table memory ports.
  logic [TABLE_W-1:0] table_mem [DEPTH];
  logic [AW-1:0]      ra_a;
  logic [AW-1:0]      ra_b;
  logic [TABLE_W-1:0] rd_a;
  logic [TABLE_W-1:0] rd_b;
  logic               we;
  logic [TABLE_W-1:0] wdata;

  logic accept;
  logic cfg_write;

  assign busy      = s1_valid;
  assign accept    = start && !s1_valid;
  assign cfg_ready = !s1_valid;
  assign cfg_write = cfg_valid && cfg_ready;

  // Element sign-extended from its low ELEMENT_BITS bits.
  logic [TABLE_W-1:0] raw_elem;
  logic [TABLE_W-1:0] elem;

  assign raw_elem = {{(TABLE_W-ELEM_W){1'b0}}, item.element_value};

  always_comb begin
    for (int i = 0; i < TABLE_W; i++) begin
      elem[i] = (i < ELEMENT_BITS) ? raw_elem[i] : raw_elem[ELEMENT_BITS-1];
    end
  end

  // Effective load position, row sum and next position.
  logic               pos_wrap;
  logic [RIW-1:0]     eff_row;
  logic [CIW-1:0]     eff_col;
  logic [TABLE_W-1:0] row_running_sum_next;
  logic [RIW-1:0]     load_row_next;
  logic [CIW-1:0]     load_col_next;

  always_comb begin
    pos_wrap = (32'(load_row) >= 32'(rows_eff)) || (32'(load_col) >= 32'(cols_eff));
    eff_row  = pos_wrap ? '0 : load_row;
    eff_col  = pos_wrap ? '0 : load_col;
    row_running_sum_next = (eff_col == '0) ? elem : row_running_sum + elem;
    if (32'(eff_col) + 32'd1 >= 32'(cols_eff)) begin
      load_col_next = '0;
      if (32'(eff_row) + 32'd1 >= 32'(rows_eff)) begin
        load_row_next = '0;
      end else begin
        load_row_next = eff_row + RIW'(1);
      end
    end else begin
      load_col_next = eff_col + CIW'(1);
      load_row_next = eff_row;
    end
  end

  // Query corners, range check and first-pair addresses.
  logic [RIW-1:0] q_brow;
  logic [RIW-1:0] q_tm1;
  logic [CIW-1:0] q_rcol;
  logic [CIW-1:0] q_lm1;
  logic           q_err;

  always_comb begin
    q_brow = RIW'(item.bottom_row);
    q_tm1  = RIW'(item.top_row - CORNER_W'(1));
    q_rcol = CIW'(item.right_col);
    q_lm1  = CIW'(item.left_col - CORNER_W'(1));
    q_err  = (item.bottom_row < item.top_row) || (item.right_col < item.left_col) ||
             (32'(item.bottom_row) >= 32'(rows_eff)) ||
             (32'(item.right_col) >= 32'(cols_eff));
  end

  // Read address selection: second query pair in the busy cycle, else the new item.
  always_comb begin
    if (s1_valid) begin
      ra_a = addr_of(s1_brow, s1_lm1);
      ra_b = addr_of(s1_tm1, s1_lm1);
    end else if (item.mode == MODE_QUERY) begin
      ra_a = addr_of(q_brow, q_rcol);
      ra_b = addr_of(q_tm1, q_rcol);
    end else begin
      ra_a = addr_of(eff_row - RIW'(1), eff_col);
      ra_b = addr_of(eff_row, eff_col);
    end
  end

  // Load write in the busy cycle: row sum plus the entry above.
  assign we    = s1_valid && (s1_mode == MODE_LOAD);
  assign wdata = row_running_sum + (s1_above ? rd_a : '0);

  // Table memory with registered reads.
  always_ff @(posedge clk) begin
    if (we) begin
      table_mem[s1_waddr] <= wdata;
    end
    rd_a <= table_mem[ra_a];
    rd_b <= table_mem[ra_b];
  end

  // Configuration and load state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use     <= DIM_W'(64);
      cols_in_use     <= DIM_W'(64);
      load_row        <= '0;
      load_col        <= '0;
      row_running_sum <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROWS_IN_USE: rows_in_use <= cfg_data;
        REG_COLS_IN_USE: cols_in_use <= cfg_data;
        default: ;
      endcase
      load_row        <= '0;
      load_col        <= '0;
      row_running_sum <= '0;
    end else if (accept && item.mode == MODE_LOAD) begin
      load_row        <= load_row_next;
      load_col        <= load_col_next;
      row_running_sum <= row_running_sum_next;
    end
  end

  // First stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  // First stage payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode  <= item.mode;
      s1_err   <= q_err;
      s1_tnz   <= item.top_row != '0;
      s1_lnz   <= item.left_col != '0;
      s1_brow  <= q_brow;
      s1_tm1   <= q_tm1;
      s1_lm1   <= q_lm1;
      s1_above <= eff_row != '0;
      s1_waddr <= addr_of(eff_row, eff_col);
    end
  end

  // Second query stage: bottom-right minus top-right.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && (s1_mode == MODE_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_err <= s1_err;
      s2_tnz <= s1_tnz;
      s2_lnz <= s1_lnz;
      s2_acc <= rd_a - (s1_tnz ? rd_b : '0);
    end
  end

  // Final sum with the left-edge terms, then saturation to the result width.
  logic [TABLE_W-1:0]     acc_full;
  logic signed [SUM_W-1:0] sum_sat;

  always_comb begin
    acc_full = s2_acc - (s2_lnz ? rd_a : '0) + ((s2_tnz && s2_lnz) ? rd_b : '0);
    if ((&acc_full[TABLE_W-1:SUM_W-1]) || !(|acc_full[TABLE_W-1:SUM_W-1])) begin
      sum_sat = signed'(acc_full[SUM_W-1:0]);
    end else if (acc_full[TABLE_W-1]) begin
      sum_sat = SUM_MIN;
    end else begin
      sum_sat = SUM_MAX;
    end
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      result.region_sum  <= s2_err ? '0 : sum_sat;
      result.coord_error <= s2_err;
    end
  end

  // Checks on the item pipeline.
  `SAT_ASSERT_NOW(a_query_result_timing, accept && item.mode == MODE_QUERY, ##3 done, "query transfer without result three edges later")
  `SAT_ASSERT_NOW(a_result_from_query, done, $past(accept && item.mode == MODE_QUERY, 3), "result strobe without a matching query transfer")
  `SAT_ASSERT_NOW(a_error_zero_sum, done && result.coord_error, result.region_sum == '0, "error result carries a nonzero sum")
  `SAT_ASSERT_NOW(a_write_after_load, we, $past(accept && item.mode == MODE_LOAD), "table write without a load transfer")
  `SAT_ASSERT_NEXT(a_busy_one_cycle, busy, !busy, "item occupies more than one busy cycle")

endmodule

>>> dv/sat_region_sum_checker.sv
// Checker that predicts and compares the region sums of the summed-area table block.
`timescale 1ns / 1ps

module sat_region_sum_checker
  import sat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  sat_in_t              item,
  input  logic                 done,
  input  sat_out_t             result,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  output int                   mismatch_count,
  output int                   pending_count
);

  localparam int ROWS = MAX_ROWS_DEF;
  localparam int COLS = MAX_COLS_DEF;
  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the table, the load position and the size registers.
  logic [TABLE_W-1:0] prefix_sums [ROWS*COLS];
  logic [TABLE_W-1:0] row_total;
  int unsigned        fill_row;
  int unsigned        fill_col;
  logic [DIM_W-1:0]   rows_reg;
  logic [DIM_W-1:0]   cols_reg;

  // Region sums still owed by the block, oldest first.
  sat_out_t expected_sums[$];
  sat_out_t owed;

  // A size of zero acts as one, a size past the table acts as the table size.
  function automatic int unsigned dim_of(logic [DIM_W-1:0] v, int unsigned cap);
    if (v == '0) return 1;
    if (v > cap) return cap;
    return 32'(v);
  endfunction

  function automatic logic [TABLE_W-1:0] entry_at(int unsigned r, int unsigned c);
    return prefix_sums[(r * COLS + c) % (ROWS * COLS)];
  endfunction

  // Fold one element into the running row sum and store its prefix sum.
  task automatic absorb_element(logic signed [ELEM_W-1:0] v);
    int unsigned        nrows;
    int unsigned        ncols;
    logic [TABLE_W-1:0] elem;
    logic [TABLE_W-1:0] above;
    nrows = dim_of(rows_reg, ROWS);
    ncols = dim_of(cols_reg, COLS);
    elem = {{(TABLE_W-ELEM_W){v[ELEM_W-1]}}, v};
    if (fill_row >= nrows || fill_col >= ncols) begin
      fill_row = 0;
      fill_col = 0;
    end
    row_total = (fill_col == 0) ? elem : row_total + elem;
    above = (fill_row > 0) ? entry_at(fill_row - 1, fill_col) : '0;
    prefix_sums[fill_row * COLS + fill_col] = row_total + above;
    fill_col++;
    if (fill_col >= ncols) begin
      fill_col = 0;
      fill_row++;
      if (fill_row >= nrows) fill_row = 0;
    end
  endtask

  // Rectangle sum from four table entries, saturated to the result width.
  function automatic sat_out_t region_answer(sat_in_t q);
    int unsigned               t;
    int unsigned               l;
    int unsigned               b;
    int unsigned               r;
    logic [TABLE_W-1:0]        acc;
    logic signed [TABLE_W-1:0] s;
    sat_out_t                  ans;
    t = 32'(q.top_row);
    l = 32'(q.left_col);
    b = 32'(q.bottom_row);
    r = 32'(q.right_col);
    ans.region_sum = '0;
    ans.coord_error = 1'b1;
    if (b < t || r < l || b >= dim_of(rows_reg, ROWS) || r >= dim_of(cols_reg, COLS)) begin
      return ans;
    end
    acc = entry_at(b, r);
    if (t > 0) acc -= entry_at(t - 1, r);
    if (l > 0) acc -= entry_at(b, l - 1);
    if (t > 0 && l > 0) acc += entry_at(t - 1, l - 1);
    s = acc;
    if (s > SUM_MAX) ans.region_sum = SUM_MAX;
    else if (s < SUM_MIN) ans.region_sum = SUM_MIN;
    else ans.region_sum = s[SUM_W-1:0];
    ans.coord_error = 1'b0;
    return ans;
  endfunction

  task automatic report_mismatch(bit orphan, sat_out_t want, sat_out_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      if (orphan) begin
        $display("[%0t] result with no query waiting: sum %0d error %0b",
                 $realtime, $signed(got.region_sum), got.coord_error);
      end else begin
        $display("[%0t] region sum mismatch: expected sum %0d error %0b, got sum %0d error %0b",
                 $realtime, $signed(want.region_sum), want.coord_error,
                 $signed(got.region_sum), got.coord_error);
      end
    end
  endtask

  // Results are checked before this edge's transfers are folded in.
  always @(posedge clk) begin
    if (rst) begin
      row_total = '0;
      fill_row = 0;
      fill_col = 0;
      rows_reg = DIM_W'(ROWS);
      cols_reg = DIM_W'(COLS);
      expected_sums.delete();
    end else begin
      if (done) begin
        if (expected_sums.size() == 0) begin
          report_mismatch(1'b1, result, result);
        end else begin
          owed = expected_sums.pop_front();
          if (result.region_sum !== owed.region_sum || result.coord_error !== owed.coord_error) begin
            report_mismatch(1'b0, owed, result);
          end
        end
      end
      if (start && !busy) begin
        if (item.mode == MODE_LOAD) absorb_element(item.element_value);
        else expected_sums.insert(expected_sums.size(), region_answer(item));
      end
      // A size write restarts the load at the first element.
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ROWS_IN_USE) rows_reg = cfg_data;
        else cols_reg = cfg_data;
        fill_row = 0;
        fill_col = 0;
        row_total = '0;
      end
    end
    pending_count = expected_sums.size();
  end

endmodule

>>> dv/tb_summed_area_table_region_sum_top.sv
// Testbench top that drives loads, queries and size changes into the summed-area table block.
`timescale 1ns / 1ps

module tb_summed_area_table_region_sum_top;
  import sat_pkg::*;

  localparam int ROWS = MAX_ROWS_DEF;
  localparam int COLS = MAX_COLS_DEF;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  sat_in_t              item = '0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 busy;
  logic                 done;
  logic                 cfg_ready;
  sat_out_t             result;
  int                   mismatches;
  int                   awaiting;
  int unsigned          cycle_count = 0;

  // Where the next load lands, and which table entries hold data.
  int unsigned active_rows = ROWS;
  int unsigned active_cols = COLS;
  int unsigned next_row = 0;
  int unsigned next_col = 0;
  bit          written [ROWS*COLS];
  bit          no_gaps = 1'b0;
  int unsigned items_sent = 0;

  always #6 clk = ~clk;

  summed_area_table_region_sum_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sat_region_sum_checker u_sum_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .item           (item),
    .done           (done),
    .result         (result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatches),
    .pending_count  (awaiting)
  );

  // Give up on a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned dim_of(logic [DIM_W-1:0] v, int unsigned cap);
    if (v == '0) return 1;
    if (v > cap) return cap;
    return 32'(v);
  endfunction

  // Mostly back-to-back, sometimes a short gap, now and then a long pause.
  function automatic int unsigned gap_cycles();
    int unsigned roll;
    if (no_gaps) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic signed [ELEM_W-1:0] random_element();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Small sizes most of the time; the extremes only where asked for.
  function automatic logic [DIM_W-1:0] pick_dim(bit edge_ok);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return DIM_W'($urandom_range(1, 6));
      6, 7: return DIM_W'($urandom_range(1, 16));
      default: begin
        if (!edge_ok) return DIM_W'($urandom_range(1, 16));
        case ($urandom_range(0, 3))
          0: return '0;
          1: return DIM_W'(1);
          2: return DIM_W'(64);
          default: return DIM_W'($urandom_range(65, 127));
        endcase
      end
    endcase
  endfunction

  // A query may only touch entries that some load has already written.
  function automatic bit readable(int unsigned t, int unsigned l, int unsigned b, int unsigned r);
    if (!written[b * COLS + r]) return 1'b0;
    if (t > 0 && !written[(t - 1) * COLS + r]) return 1'b0;
    if (l > 0 && !written[b * COLS + l - 1]) return 1'b0;
    if (t > 0 && l > 0 && !written[(t - 1) * COLS + l - 1]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit corners_valid(int unsigned t, int unsigned l, int unsigned b,
                                       int unsigned r);
    return b >= t && r >= l && b < active_rows && r < active_cols;
  endfunction

  // Present one item and return at the edge of its transfer.
  task automatic issue(sat_in_t it);
    int unsigned gap;
    gap = gap_cycles();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    // Busy only moves at rising edges, so its value mid-cycle decides the next edge.
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic load_element(logic signed [ELEM_W-1:0] v);
    sat_in_t it;
    it.mode = MODE_LOAD;
    it.element_value = v;
    it.top_row = CORNER_W'($urandom);
    it.left_col = CORNER_W'($urandom);
    it.bottom_row = CORNER_W'($urandom);
    it.right_col = CORNER_W'($urandom);
    issue(it);
    written[next_row * COLS + next_col] = 1'b1;
    next_col++;
    if (next_col >= active_cols) begin
      next_col = 0;
      next_row++;
      if (next_row >= active_rows) next_row = 0;
    end
  endtask

  task automatic ask(int unsigned t, int unsigned l, int unsigned b, int unsigned r);
    sat_in_t it;
    it.mode = MODE_QUERY;
    it.element_value = ELEM_W'($urandom);
    it.top_row = CORNER_W'(t);
    it.left_col = CORNER_W'(l);
    it.bottom_row = CORNER_W'(b);
    it.right_col = CORNER_W'(r);
    issue(it);
  endtask

  // Mostly in-range rectangles over written data; the rest use random corners or ones past the size.
  task automatic random_query();
    int unsigned t;
    int unsigned l;
    int unsigned b;
    int unsigned r;
    int unsigned kind;
    bit          ok;
    kind = $urandom_range(0, 9);
    ok = 1'b0;
    if (kind < 7) begin
      repeat (8) begin
        if (!ok) begin
          b = $urandom_range(0, active_rows - 1);
          t = $urandom_range(0, b);
          r = $urandom_range(0, active_cols - 1);
          l = $urandom_range(0, r);
          ok = readable(t, l, b, r);
        end
      end
    end else if (kind < 9) begin
      t = $urandom_range(0, 63);
      l = $urandom_range(0, 63);
      b = $urandom_range(0, 63);
      r = $urandom_range(0, 63);
      ok = !corners_valid(t, l, b, r) || readable(t, l, b, r);
    end else if (active_rows < ROWS) begin
      b = $urandom_range(active_rows, 63);
      t = $urandom_range(0, b);
      r = $urandom_range(0, 63);
      l = $urandom_range(0, r);
      ok = 1'b1;
    end else if (active_cols < COLS) begin
      r = $urandom_range(active_cols, 63);
      l = $urandom_range(0, r);
      b = $urandom_range(0, 63);
      t = $urandom_range(0, b);
      ok = 1'b1;
    end
    // Fall back to an inverted rectangle, which reads nothing.
    if (!ok) begin
      l = $urandom_range(1, 63);
      r = $urandom_range(0, l - 1);
      t = $urandom_range(0, 63);
      b = $urandom_range(0, 63);
    end
    ask(t, l, b, r);
  endtask

  // Stop issuing and wait until the block has nothing left in flight.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (awaiting != 0 || busy) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(logic [CFG_IDX_W-1:0] which, logic [DIM_W-1:0] value, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    if (last) cfg_valid <= 1'b0;
    if (which == REG_ROWS_IN_USE) active_rows = dim_of(value, ROWS);
    else active_cols = dim_of(value, COLS);
    next_row = 0;
    next_col = 0;
  endtask

  task automatic resize(bit set_rows, logic [DIM_W-1:0] rv, bit set_cols, logic [DIM_W-1:0] cv);
    drain();
    if (set_rows) set_size(REG_ROWS_IN_USE, rv, !set_cols);
    if (set_cols) set_size(REG_COLS_IN_USE, cv, 1'b1);
  endtask

  initial begin : stimulus
    logic signed [ELEM_W-1:0] firsts [6];
    logic [DIM_W-1:0]         rv;
    logic [DIM_W-1:0]         cv;
    int unsigned              pick;
    int unsigned              cells;
    int unsigned              loads;
    int unsigned              base;
    firsts = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh3039};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // A 2x3 matrix with extreme elements, then rectangles of every shape and bad corners.
    resize(1'b1, DIM_W'(2), 1'b1, DIM_W'(3));
    foreach (firsts[i]) load_element(firsts[i]);
    ask(0, 0, 1, 2);
    ask(1, 1, 1, 2);
    ask(0, 2, 0, 2);
    ask(1, 0, 0, 2);
    ask(0, 2, 1, 1);
    ask(0, 0, 2, 2);
    ask(0, 0, 1, 3);
    ask(63, 63, 63, 63);
    // The load wrapped; a partial reload leaves stale entries in the second row.
    load_element(16'sh8000);
    load_element(16'sh8000);
    ask(1, 0, 1, 2);
    ask(0, 0, 0, 1);

    // Eight full-width rows of the largest element, then a first row of the smallest:
    // the new row is mixed with the old table below it.
    resize(1'b1, DIM_W'(8), 1'b1, DIM_W'(64));
    repeat (8 * COLS) load_element(16'sh7FFF);
    ask(0, 0, 7, 63);
    ask(0, 0, 0, 0);
    ask(7, 63, 7, 63);
    resize(1'b0, '0, 1'b1, DIM_W'(64));
    repeat (COLS) load_element(16'sh8000);
    ask(1, 0, 7, 63);
    ask(1, 1, 7, 63);
    ask(0, 0, 0, 63);

    // Random sizes, full and partial matrices, with queries mixed into the loads.
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      rv = pick_dim(1'b1);
      if (dim_of(rv, ROWS) > 16) cv = DIM_W'($urandom_range(0, 4));
      else cv = pick_dim(dim_of(rv, ROWS) <= 4);
      // Keep the matrix small when only one register changes.
      pick = $urandom_range(0, 3);
      if (pick == 0 && dim_of(rv, ROWS) * active_cols > 256) pick = 2;
      if (pick == 1 && active_rows * dim_of(cv, COLS) > 256) pick = 2;
      resize(pick != 1, rv, pick != 0, cv);
      no_gaps = ($urandom_range(0, 3) == 0);
      cells = active_rows * active_cols;
      loads = ($urandom_range(0, 9) < 7) ? cells : $urandom_range(1, cells);
      if ($urandom_range(0, 9) == 0) loads += $urandom_range(1, cells);
      while (loads > 0) begin
        if ($urandom_range(0, 3) == 0) begin
          random_query();
        end else begin
          load_element(random_element());
          loads--;
        end
      end
      repeat ($urandom_range(2, 10)) random_query();
    end

    no_gaps = 1'b0;
    drain();
    if (mismatches == 0 && awaiting == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
